// File: rtl/core/bee_pkg.sv
// ----------------------------------------------------------------------------
// bee_pkg
// shared types and constants of the bow excitation envelope
// ----------------------------------------------------------------------------
`default_nettype none

package bee_pkg;

    localparam int LEVEL_W   = 24;
    localparam int PROD_W    = 2 * LEVEL_W;
    localparam int MULT_W    = 16;
    localparam int VEL_W     = 7;
    localparam int VEL_DEPTH = 1 << VEL_W;

    localparam logic [LEVEL_W-1:0] Q24_MAX         = 24'hFF_FFFF;
    localparam logic [LEVEL_W-1:0] RELEASE_RESET   = 24'd16765569;
    localparam logic [LEVEL_W-1:0] SPEED_THRESHOLD = 24'd1677;
    localparam logic [LEVEL_W-1:0] ONE_LSB         = 24'd1;
    localparam logic [PROD_W:0]    Q24_HALF        = 49'h80_0000;
    localparam logic [PROD_W:0]    Q15_HALF        = 49'h4000;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_START    = 3'd1,
        OP_STOP     = 3'd2,
        OP_SPEED    = 3'd3,
        OP_PRESSURE = 3'd4,
        OP_CLEAR    = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ISSUE_A,
        S_ISSUE_B,
        S_WB_A,
        S_WB_B,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/core/bee_if.sv
// ----------------------------------------------------------------------------
// bee_if
// valid/ready channels for the envelope command and level beats
// ----------------------------------------------------------------------------
`default_nettype none

interface bee_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [6:0]  velocity;
    logic [23:0] value;

    modport source (output valid, output operation, output velocity, output value,
                    input ready);
    modport sink   (input valid, input operation, input velocity, input value,
                    output ready);
endinterface

interface bee_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] bow_velocity;
    logic [23:0] bow_force;
    logic        sounding;

    modport source (output valid, output bow_velocity, output bow_force,
                    output sounding, input ready);
    modport sink   (input valid, input bow_velocity, input bow_force,
                    input sounding, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bee_rom.sv
// ----------------------------------------------------------------------------
// bee_rom
// velocity tables: target multiplier and attack coefficient, registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bee_rom
    import bee_pkg::*;
#(
    parameter int SAMPLE_RATE = 48000
)(
    input  logic               clk,
    input  logic [VEL_W-1:0]   vel,
    output logic [MULT_W-1:0]  mult,
    output logic [LEVEL_W-1:0] coeff
);

    logic [MULT_W-1:0]  mult_tab  [VEL_DEPTH];
    logic [LEVEL_W-1:0] coeff_tab [VEL_DEPTH];

    for (genvar i = 0; i < VEL_DEPTH; i++)
    begin : g_entry
        // attack time from 50 ms down to 5 ms, x = 1/(t*fs) in q0.32
        localparam logic [63:0] DEN = 64'(6350 - 45 * i) * 64'(SAMPLE_RATE);
        localparam logic [63:0] XR  = ((64'd127000 << 32) + DEN / 2) / DEN;
        localparam logic [63:0] X   = (XR > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : XR;
        localparam logic [63:0] P2  = (X * X) >> 32;
        localparam logic [63:0] P3  = (P2 * X) >> 32;
        localparam logic [63:0] P4  = (P3 * X) >> 32;
        localparam logic [63:0] P5  = (P4 * X) >> 32;
        // 1 - exp(-x) from the series through x^5
        localparam longint C0 = longint'(X) - longint'(P2 / 2) + longint'(P3 / 6)
                                - longint'(P4 / 24) + longint'(P5 / 120);
        localparam longint C1 = (C0 < 0) ? 0 : C0;
        localparam longint C2 = (C1 + 128) / 256;
        localparam longint C3 = (C2 > longint'(Q24_MAX)) ? longint'(Q24_MAX) : C2;
        localparam logic [31:0] M = (32'd32768 * (32'd254 + 32'(8 * i)) + 32'd635)
                                    / 32'd1270;

        assign mult_tab[i]  = MULT_W'(M);
        assign coeff_tab[i] = LEVEL_W'(C3);
    end

    always_ff @(posedge clk)
    begin
        mult  <= mult_tab[vel];
        coeff <= coeff_tab[vel];
    end

endmodule

`default_nettype wire

// File: rtl/core/bee_mul.sv
// ----------------------------------------------------------------------------
// bee_mul
// shared 24x24 multiplier, registered operands and registered product
// ----------------------------------------------------------------------------
`default_nettype none

module bee_mul
    import bee_pkg::*;
(
    input  logic               clk,
    input  logic [LEVEL_W-1:0] a,
    input  logic [LEVEL_W-1:0] b,
    output logic [PROD_W-1:0]  prod
);

    logic [LEVEL_W-1:0] a_reg;
    logic [LEVEL_W-1:0] b_reg;
    logic [PROD_W-1:0]  prod_reg;

    always_ff @(posedge clk)
    begin
        a_reg    <= a;
        b_reg    <= b;
        prod_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/core/bow_excitation_envelope.sv
// ----------------------------------------------------------------------------
// bow_excitation_envelope
// two-channel attack/release envelope for bow velocity and bow force
//
// din carries command beats (tick, start, stop, set speed, set pressure,
// clear); dout returns one beat per command with both levels in q0.24 and
// the sounding flag. cfg_we/cfg_wdata write the release coefficient.
// a command is taken only while the sequencer is idle. a tick runs through
// dispatch, two issue and two write-back states; start and set speed run
// through dispatch, both issue states and the first write-back; the rest go
// from dispatch to done. these states serve the shared two-stage multiplier,
// used once per channel on a tick, once for the target on start/set speed.
// the finished levels go to an output register, so a new command is taken
// while the previous result still waits; if the receiver stalls and the
// output register is still full when the next command finishes, the block
// holds that command's result until dout.ready and takes nothing meanwhile.
// reset clears all levels, targets, settings and the note flag and loads
// the release coefficient for 30 ms at 48 kHz.
// ----------------------------------------------------------------------------
`default_nettype none

module bow_excitation_envelope
    import bee_pkg::*;
#(
    parameter int SAMPLE_RATE = 48000
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [23:0] cfg_wdata,
    bee_in_if.sink      din,
    bee_out_if.source   dout
);

    state_t state_reg, state_next;

    op_t                op_reg;
    logic [VEL_W-1:0]   vel_reg;
    logic [LEVEL_W-1:0] val_reg;

    logic [LEVEL_W-1:0] release_reg;
    logic [LEVEL_W-1:0] vel_level_reg, vel_level_next;
    logic [LEVEL_W-1:0] frc_level_reg, frc_level_next;
    logic [LEVEL_W-1:0] vel_target_reg, vel_target_next;
    logic [LEVEL_W-1:0] frc_target_reg, frc_target_next;
    logic [LEVEL_W-1:0] speed_reg, speed_next;
    logic [LEVEL_W-1:0] pressure_reg, pressure_next;
    logic [MULT_W-1:0]  smult_reg, smult_next;
    logic [LEVEL_W-1:0] attack_reg, attack_next;
    logic               note_on_reg, note_on_next;

    logic               out_valid_reg, out_valid_next;
    logic [LEVEL_W-1:0] out_vel_reg;
    logic [LEVEL_W-1:0] out_frc_reg;
    logic               out_snd_reg;
    logic               out_load;

    logic               accept;
    logic               ch_force;
    logic [LEVEL_W-1:0] sel_level;
    logic [LEVEL_W-1:0] sel_target;
    logic               up;
    logic [LEVEL_W-1:0] diff;
    logic [LEVEL_W-1:0] mul_a;
    logic [LEVEL_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic [MULT_W-1:0]  rom_mult;
    logic [LEVEL_W-1:0] rom_coeff;

    logic [PROD_W:0]    round_sum;
    logic [LEVEL_W:0]   step;
    logic [LEVEL_W-1:0] step_lim;
    logic [LEVEL_W-1:0] approach_val;
    logic [LEVEL_W-1:0] tick_val;
    logic [PROD_W:0]    scale_sum;
    logic [PROD_W-15:0] scale_full;
    logic [LEVEL_W-1:0] scale_val;

    bee_rom #(
        .SAMPLE_RATE (SAMPLE_RATE)
    ) u_rom (
        .clk   (clk),
        .vel   (vel_reg),
        .mult  (rom_mult),
        .coeff (rom_coeff)
    );

    bee_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign din.ready = (state_reg == S_IDLE);
    assign accept    = din.valid && din.ready;

    // channel select: velocity in the first slot, force in the second
    assign ch_force   = (state_reg == S_ISSUE_B) || (state_reg == S_WB_B);
    assign sel_level  = ch_force ? frc_level_reg : vel_level_reg;
    assign sel_target = ch_force ? frc_target_reg : vel_target_reg;
    assign up         = (sel_target >= sel_level);
    assign diff       = up ? (sel_target - sel_level) : (sel_level - sel_target);

    always_comb
    begin
        mul_a = sel_level;
        mul_b = release_reg;
        case (op_reg)
            OP_TICK:
            begin
                mul_a = note_on_reg ? diff : sel_level;
                mul_b = note_on_reg ? attack_reg : release_reg;
            end
            OP_START:
            begin
                mul_a = speed_reg;
                mul_b = LEVEL_W'(rom_mult);
            end
            OP_SPEED:
            begin
                mul_a = val_reg;
                mul_b = LEVEL_W'(smult_reg);
            end
            default:
            begin
                mul_a = sel_level;
                mul_b = release_reg;
            end
        endcase
    end

    // post-processing of the product
    assign round_sum    = {1'b0, prod} + Q24_HALF;
    assign step         = round_sum[PROD_W:LEVEL_W];
    assign step_lim     = (step > {1'b0, diff}) ? diff : step[LEVEL_W-1:0];
    assign approach_val = up ? (sel_level + step_lim) : (sel_level - step_lim);
    assign tick_val     = note_on_reg ? approach_val : prod[PROD_W-1:LEVEL_W];
    assign scale_sum    = {1'b0, prod} + Q15_HALF;
    assign scale_full   = scale_sum[PROD_W:15];
    assign scale_val    = (|scale_full[PROD_W-15:LEVEL_W]) ? Q24_MAX
                                                           : scale_full[LEVEL_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            release_reg    <= RELEASE_RESET;
            vel_level_reg  <= '0;
            frc_level_reg  <= '0;
            vel_target_reg <= '0;
            frc_target_reg <= '0;
            speed_reg      <= '0;
            pressure_reg   <= '0;
            smult_reg      <= '0;
            attack_reg     <= '0;
            note_on_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                release_reg <= cfg_wdata;
            end
            vel_level_reg  <= vel_level_next;
            frc_level_reg  <= frc_level_next;
            vel_target_reg <= vel_target_next;
            frc_target_reg <= frc_target_next;
            speed_reg      <= speed_next;
            pressure_reg   <= pressure_next;
            smult_reg      <= smult_next;
            attack_reg     <= attack_next;
            note_on_reg    <= note_on_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(din.operation);
            vel_reg <= din.velocity;
            val_reg <= din.value;
        end
        if (out_load)
        begin
            out_vel_reg <= vel_level_reg;
            out_frc_reg <= frc_level_reg;
            out_snd_reg <= note_on_reg || (vel_level_reg > ONE_LSB);
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        vel_level_next  = vel_level_reg;
        frc_level_next  = frc_level_reg;
        vel_target_next = vel_target_reg;
        frc_target_next = frc_target_reg;
        speed_next      = speed_reg;
        pressure_next   = pressure_reg;
        smult_next      = smult_reg;
        attack_next     = attack_reg;
        note_on_next    = note_on_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_TICK, OP_START, OP_SPEED:
                    begin
                        state_next = S_ISSUE_A;
                    end
                    OP_STOP:
                    begin
                        note_on_next = 1'b0;
                    end
                    OP_PRESSURE:
                    begin
                        pressure_next = val_reg;
                        if (note_on_reg)
                        begin
                            frc_target_next = val_reg;
                        end
                    end
                    OP_CLEAR:
                    begin
                        vel_level_next  = '0;
                        frc_level_next  = '0;
                        vel_target_next = '0;
                        frc_target_next = '0;
                        note_on_next    = 1'b0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ISSUE_A:
            begin
                if (op_reg == OP_START)
                begin
                    vel_level_next = '0;
                    frc_level_next = '0;
                    smult_next     = rom_mult;
                    attack_next    = rom_coeff;
                end
                state_next = S_ISSUE_B;
            end
            S_ISSUE_B:
            begin
                state_next = S_WB_A;
            end
            S_WB_A:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        vel_level_next = tick_val;
                        state_next     = S_WB_B;
                    end
                    OP_START:
                    begin
                        vel_target_next = scale_val;
                        frc_target_next = pressure_reg;
                        note_on_next    = 1'b1;
                    end
                    OP_SPEED:
                    begin
                        if (note_on_reg && (speed_reg > SPEED_THRESHOLD))
                        begin
                            vel_target_next = scale_val;
                        end
                        speed_next = val_reg;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WB_B:
            begin
                frc_level_next = tick_val;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.bow_velocity = out_vel_reg;
    assign dout.bow_force    = out_frc_reg;
    assign dout.sounding     = out_snd_reg;

    // an accepted beat always starts decoding next cycle
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DISPATCH))
        else $error("accepted beat did not reach dispatch");

    // a result beat appears only out of the done state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside done state");

    // attack step stays between old level and target
    a_attack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB_A && op_reg == OP_TICK && note_on_reg) |=>
        ((vel_level_reg >= $past(vel_level_reg) &&
          vel_level_reg <= $past(vel_target_reg)) ||
         (vel_level_reg <= $past(vel_level_reg) &&
          vel_level_reg >= $past(vel_target_reg))))
        else $error("attack step overshot the target");

    // release never raises the level
    a_release_decay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WB_A && op_reg == OP_TICK && !note_on_reg) |=>
        (vel_level_reg <= $past(vel_level_reg)))
        else $error("release step raised the level");

endmodule

`default_nettype wire
